@@ hw/rtl/kabf_pkg.sv @@
// ----------------------------------------------------------------------------
// kabf_pkg
// shared types, constants and fixed-point helpers of the angle/bias filter
// ----------------------------------------------------------------------------
package kabf_pkg;

	localparam int AXIS_COUNT_DEF = 2;
	localparam int CFG_W          = 31;
	localparam int CFG_IDX_W      = 2;
	localparam int DATA_W         = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PN_ANGLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PN_BIAS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MEAS_N   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd3;

	localparam logic [CFG_W-1:0] PN_ANGLE_RST = 31'd1073742;
	localparam logic [CFG_W-1:0] PN_BIAS_RST  = 31'd3221225;
	localparam logic [CFG_W-1:0] MEAS_N_RST   = 31'd536870912;
	localparam logic [CFG_W-1:0] PERIOD_RST   = 31'd21474836;

	localparam logic signed [DATA_W-1:0] ONE_Q30 = 32'sd1073741824;

	typedef logic signed [DATA_W-1:0] q_t;

	// divider request and response
	typedef struct packed {
		logic start;
		q_t   num;
		q_t   den;
	} div_req_t;

	typedef struct packed {
		logic done;
		q_t   quot;
	} div_rsp_t;

	function automatic q_t sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -66'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// product already registered: round half up by 2^30, saturate
	function automatic q_t rnd_q30(input logic signed [63:0] p);
		logic signed [65:0] s;
		s = ($signed({{2{p[63]}}, p}) + 66'sd536870912) >>> 30;
		return sat32(s);
	endfunction

endpackage

@@ hw/rtl/kabf_div.sv @@
// ----------------------------------------------------------------------------
// kabf_div
// restoring divider, one quotient bit per cycle: (num * 2^30) / den, truncated
// toward zero and saturated to 32 bits
// ----------------------------------------------------------------------------
module kabf_div
	import kabf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int NW = 62;
	localparam int CW = 6;

	logic            busy_q;
	logic [CW-1:0]   cnt_q;
	logic [NW-1:0]   num_q;
	logic [32:0]     rem_q;
	logic [32:0]     den_q;
	logic [NW-1:0]   quo_q;
	logic            neg_q;
	logic            done_q;
	q_t              quot_q;
	logic [33:0]     trial;
	logic [33:0]     shifted;
	logic [NW-1:0]   quo_n;
	logic signed [65:0] signed_quo;

	assign shifted = {rem_q, num_q[NW-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign quo_n   = {quo_q[NW-2:0], ~trial[33]};
	assign signed_quo = neg_q ? -$signed({4'b0, quo_n}) : $signed({4'b0, quo_n});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= {(req.num[31] ? 32'(-{req.num[31], req.num}) : req.num), 30'b0};
			den_q <= req.den[31] ? 33'(-{req.den[31], req.den}) : {1'b0, req.den};
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= req.num[31] ^ req.den[31];
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			rem_q <= trial[33] ? shifted[32:0] : trial[32:0];
			quo_q <= quo_n;
			if (cnt_q == '0) begin
				quot_q <= sat32(signed_quo);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

@@ hw/rtl/kalman_angle_bias_filter_top.sv @@
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter_top
// two-state tilt Kalman filter with per-axis angle, bias and covariance
// ----------------------------------------------------------------------------
// One request is taken at a time. A sequencer drives one shared 32x32
// multiplier (11 products, each through ST_MUL and ST_ACC) and a
// one-bit-per-cycle divider (two gains).
// s_tready is low while a request is in flight or its result waits in the
// output register. Axis values at or above AXIS_COUNT use the last axis
// state. tdata fields: see port comments.
module kalman_angle_bias_filter_top
	import kabf_pkg::*;
#(
	parameter int AXIS_COUNT = AXIS_COUNT_DEF
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [71:0]          s_tdata,  // axis, measured_angle, gyro_rate, zero fill
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [71:0]          m_tdata   // result_axis, filtered_angle, corrected_rate, fill
);

	localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_ACC  = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_DWT  = 7'b0010000,
		ST_WB   = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [3:0] op_q;
	logic       div_sel_q;

	logic [CFG_W-1:0] pna_q, pnb_q, mn_q, dt_q;

	q_t ang_q [AXIS_COUNT];
	q_t bias_q[AXIS_COUNT];
	q_t p00_q [AXIS_COUNT];
	q_t p01_q [AXIS_COUNT];
	q_t p10_q [AXIS_COUNT];
	q_t p11_q [AXIS_COUNT];

	logic          axis_in_q;
	logic [AW-1:0] sel_q;
	logic [AW-1:0] sel_n;
	q_t meas_q, gyro_q;
	q_t ang_w, bias_w, p00_w, p01_w, p10_w, p11_w;
	q_t rate_w, d0_w, d1_w, t0_w, t1_w, err_w, den_w, k0_w, k1_w;
	q_t op_a, op_b, acc_base;
	logic acc_sub;
	logic signed [63:0] prod_s1;
	q_t m_res;
	logic [71:0] out_q;
	logic out_v_q;
	div_req_t dreq;
	div_rsp_t drsp;

	logic [AW:0] axis_ext;
	assign axis_ext = {{AW{1'b0}}, s_tdata[0]};
	assign sel_n    = (axis_ext >= (AW+1)'(AXIS_COUNT)) ? AW'(AXIS_COUNT - 1)
	                                                   : axis_ext[AW-1:0];

	kabf_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign s_tready = (state_q == ST_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;
	assign m_res    = rnd_q30(prod_s1);

	// operand selection per op
	always_comb begin
		op_a = rate_w; op_b = q_t'({1'b0, dt_q}); acc_base = ang_w; acc_sub = 1'b0;
		case (op_q)
			4'd0: begin op_a = rate_w; op_b = q_t'({1'b0, dt_q}); acc_base = ang_w; end
			4'd1: begin op_a = d0_w; op_b = q_t'({1'b0, dt_q}); acc_base = p00_w; end
			4'd2: begin op_a = d1_w; op_b = q_t'({1'b0, dt_q}); acc_base = p01_w; end
			4'd3: begin op_a = d1_w; op_b = q_t'({1'b0, dt_q}); acc_base = p10_w; end
			4'd4: begin
				op_a = q_t'({1'b0, pnb_q}); op_b = q_t'({1'b0, dt_q}); acc_base = p11_w;
			end
			4'd5: begin op_a = k0_w; op_b = t0_w; acc_base = p00_w; acc_sub = 1'b1; end
			4'd6: begin op_a = k0_w; op_b = t1_w; acc_base = p01_w; acc_sub = 1'b1; end
			4'd7: begin op_a = k1_w; op_b = t0_w; acc_base = p10_w; acc_sub = 1'b1; end
			4'd8: begin op_a = k1_w; op_b = t1_w; acc_base = p11_w; acc_sub = 1'b1; end
			4'd9: begin op_a = k0_w; op_b = err_w; acc_base = ang_w; end
			4'd10: begin op_a = k1_w; op_b = err_w; acc_base = bias_w; end
			default: begin op_a = rate_w; op_b = q_t'({1'b0, dt_q}); acc_base = ang_w; end
		endcase
	end

	q_t acc_res;
	assign acc_res = acc_sub ? sat32(66'(acc_base) - 66'(m_res))
	                         : sat32(66'(acc_base) + 66'(m_res));
	assign dreq.start = (state_q == ST_DIV);
	assign dreq.num   = div_sel_q ? p10_w : p00_w;
	assign dreq.den   = den_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			op_q <= '0;
			div_sel_q <= 1'b0;
			pna_q <= PN_ANGLE_RST; pnb_q <= PN_BIAS_RST;
			mn_q <= MEAS_N_RST; dt_q <= PERIOD_RST;
			for (int i = 0; i < AXIS_COUNT; i++) begin
				ang_q[i] <= '0; bias_q[i] <= '0; p01_q[i] <= '0; p10_q[i] <= '0;
				p00_q[i] <= ONE_Q30; p11_q[i] <= ONE_Q30;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PN_ANGLE: pna_q <= cfg_data;
					REG_PN_BIAS:  pnb_q <= cfg_data;
					REG_MEAS_N:   mn_q  <= cfg_data;
					REG_PERIOD:   dt_q  <= cfg_data;
					default: ;
				endcase
			end
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_tvalid && s_tready) begin
					state_q <= ST_MUL; op_q <= '0;
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					op_q <= op_q + 1'b1;
					if (op_q == 4'd4) state_q <= ST_DIV;
					else if (op_q == 4'd10) state_q <= ST_WB;
					else state_q <= ST_MUL;
				end
				ST_DIV: state_q <= ST_DWT;
				ST_DWT: if (drsp.done) begin
					div_sel_q <= ~div_sel_q;
					state_q <= div_sel_q ? ST_MUL : ST_DIV;
				end
				ST_WB: begin
					ang_q[sel_q] <= ang_w; bias_q[sel_q] <= bias_w;
					p00_q[sel_q] <= p00_w; p01_q[sel_q] <= p01_w;
					p10_q[sel_q] <= p10_w; p11_q[sel_q] <= p11_w;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_v_q <= 1'b1; state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (s_tvalid && s_tready) begin
				axis_in_q <= s_tdata[0];
				sel_q <= sel_n;
				meas_q <= s_tdata[32:1];
				gyro_q <= s_tdata[64:33];
				ang_w <= ang_q[sel_n]; bias_w <= bias_q[sel_n];
				p00_w <= p00_q[sel_n]; p01_w <= p01_q[sel_n];
				p10_w <= p10_q[sel_n]; p11_w <= p11_q[sel_n];
			end
			default: ;
		endcase
		prod_s1 <= op_a * op_b;
		if (state_q == ST_ACC) begin
			case (op_q)
				4'd0: ang_w <= acc_res;
				4'd1: p00_w <= acc_res;
				4'd2: p01_w <= acc_res;
				4'd3: p10_w <= acc_res;
				4'd4: begin
					p11_w <= acc_res;
					err_w <= sat32(66'(meas_q) - 66'(ang_w));
					den_w <= sat32(66'($signed({1'b0, mn_q})) + 66'(p00_w));
					t0_w <= p00_w; t1_w <= p01_w;
				end
				4'd5: p00_w <= acc_res;
				4'd6: p01_w <= acc_res;
				4'd7: p10_w <= acc_res;
				4'd8: p11_w <= acc_res;
				4'd9: ang_w <= acc_res;
				4'd10: bias_w <= acc_res;
				default: ;
			endcase
		end
		if (state_q == ST_DWT && drsp.done) begin
			if (div_sel_q) k1_w <= (den_w == '0) ? '0 : drsp.quot;
			else k0_w <= (den_w == '0) ? '0 : drsp.quot;
		end
		if (state_q == ST_OUT) begin
			out_q <= {7'b0, sat32(66'(gyro_q) - 66'(bias_w)), ang_w, axis_in_q};
		end
	end

	// combinational terms derived from the working and configuration registers
	always_comb begin
		rate_w = sat32(66'(gyro_q) - 66'(bias_w));
		d0_w   = sat32(66'($signed({1'b0, pna_q})) - 66'(p01_w) - 66'(p10_w));
		d1_w   = sat32(-66'(p11_w));
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready) else $error("accept while busy");
	a_div_only_wait: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == ST_DWT)) else $error("divider done out of place");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> m_tvalid) else $error("result lost");
`endif

endmodule
